[rtl/core/three_axis_spin_ramp_controller_unit_assert.svh]
// Assertion macros for the spin ramp controller.
// Each macro takes a label, a trigger expression and a consequent expression.
`ifndef THREE_AXIS_SPIN_RAMP_CONTROLLER_UNIT_ASSERT_SVH
`define THREE_AXIS_SPIN_RAMP_CONTROLLER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TASRC_ASSERT_IMP(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("tasrc assertion failed");
`define TASRC_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("tasrc assertion failed");
`else
`define TASRC_ASSERT_IMP(label, trig, cons)
`define TASRC_ASSERT_NEXT(label, trig, cons)
`endif
`endif

[rtl/core/tasrc_pkg.sv]
`timescale 1ns / 1ps
package tasrc_pkg;

    localparam int TIME_BITS_DEF  = 16;
    localparam int SPEED_BITS_DEF = 24;
    localparam int NUM_AXES       = 3;
    localparam int RAMP_FIELD_W   = 16;
    localparam int RAMP_PACK_W    = 48;
    localparam int ANGLE_W        = 32;
    localparam int ANGLE_OUT_W    = 16;
    localparam int STEP_W         = 28;
    localparam int MODE_W         = 2;
    localparam int PHASE_OUT_W    = 2;
    localparam int DIR_W          = 3;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_X,
        CFG_SPEED_Y,
        CFG_SPEED_Z,
        CFG_DIRECTION,
        CFG_UP_TIMES,
        CFG_DOWN_TIMES,
        CFG_START_ON
    } cfg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK,
        MODE_ON,
        MODE_OFF
    } mode_t;

    typedef enum logic [2:0] {
        PH_OFF,
        PH_UP,
        PH_NORMAL,
        PH_DOWN,
        PH_UNSTARTED
    } phase_t;

endpackage

[rtl/core/tasrc_in_if.sv]
`timescale 1ns / 1ps
interface tasrc_in_if #(
    parameter int TIME_BITS = tasrc_pkg::TIME_BITS_DEF
);
    import tasrc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [TIME_BITS-1:0] delta_time;

    modport source (output valid, mode, delta_time, input ready);
    modport sink   (input valid, mode, delta_time, output ready);
endinterface

[rtl/core/tasrc_out_if.sv]
`timescale 1ns / 1ps
interface tasrc_out_if;
    import tasrc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ANGLE_OUT_W-1:0] pitch_angle;
    logic [ANGLE_OUT_W-1:0] yaw_angle;
    logic [ANGLE_OUT_W-1:0] roll_angle;
    logic [PHASE_OUT_W-1:0] phase;

    modport source (output valid, pitch_angle, yaw_angle, roll_angle, phase, input ready);
    modport sink   (input valid, pitch_angle, yaw_angle, roll_angle, phase, output ready);
endinterface

[rtl/core/three_axis_spin_ramp_controller_unit.sv]
// Channel   Dir  Payload                                    Carries
// item      in   mode, delta_time                           tick / on / off request
// result    out  pitch_angle, yaw_angle, roll_angle, phase  one per request
// cfg       in   cfg_we, cfg_index, cfg_data                register writes
//
// Ramp tick: runs the radix-2 shift-add multiplier, restoring divider and
// angle-step multiplier, all three axes in lockstep. Normal tick: angle-step
// multiplier, then the angle update. Triggers and off-phase ticks go straight
// to the output state. One request in flight at a time.
// A finished result sits in the output register; a stalled result holds the
// unit in its output state. Reset is asynchronous, no clearing pass.
`timescale 1ns / 1ps
`include "three_axis_spin_ramp_controller_unit_assert.svh"
module three_axis_spin_ramp_controller_unit #(
    parameter int TIME_BITS  = tasrc_pkg::TIME_BITS_DEF,
    parameter int SPEED_BITS = tasrc_pkg::SPEED_BITS_DEF,
    localparam int CFG_W     = (SPEED_BITS > tasrc_pkg::RAMP_PACK_W) ?
                               SPEED_BITS : tasrc_pkg::RAMP_PACK_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tasrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]               cfg_data,
    tasrc_in_if.sink                       item,
    tasrc_out_if.source                    result
);
    import tasrc_pkg::*;

    localparam int PROD_W = SPEED_BITS + TIME_BITS;
    localparam int LEFT_W = TIME_BITS + 2;
    localparam int CNT_W  = $clog2(PROD_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_EL,
        S_DIV,
        S_MUL_DT,
        S_APPLY,
        S_OUT
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    phase_t                 phase_reg;
    logic                   up_reg;
    logic [TIME_BITS-1:0]   dt_sh_reg;

    logic [SPEED_BITS-1:0]  speed_reg      [NUM_AXES];
    logic [DIR_W-1:0]       dir_reg;
    logic [RAMP_PACK_W-1:0] up_times_reg;
    logic [RAMP_PACK_W-1:0] down_times_reg;
    logic                   start_on_reg;

    logic [ANGLE_W-1:0]     acc_reg        [NUM_AXES];
    logic [SPEED_BITS-1:0]  cur_speed_reg  [NUM_AXES];
    logic [LEFT_W-1:0]      time_left_reg  [NUM_AXES];
    logic [NUM_AXES-1:0]    done_reg;
    logic [TIME_BITS-1:0]   el_sh_reg      [NUM_AXES];
    logic [TIME_BITS-1:0]   t_reg          [NUM_AXES];
    logic [PROD_W-1:0]      prod_reg       [NUM_AXES];
    logic [TIME_BITS-1:0]   rem_reg        [NUM_AXES];
    logic [STEP_W-1:0]      step_reg       [NUM_AXES];

    logic                   res_valid_reg;
    logic [ANGLE_OUT_W-1:0] out_angle_reg  [NUM_AXES];
    logic [PHASE_OUT_W-1:0] out_phase_reg;

    phase_t                 ph_eff;
    phase_t                 ph_acc;
    logic                   ramp_up;
    logic [TIME_BITS-1:0]   t_up           [NUM_AXES];
    logic [TIME_BITS-1:0]   t_dn           [NUM_AXES];
    logic [TIME_BITS-1:0]   t_sel          [NUM_AXES];
    logic [LEFT_W-1:0]      left_diff      [NUM_AXES];
    logic [LEFT_W-1:0]      left_new       [NUM_AXES];
    logic [TIME_BITS-1:0]   el_new         [NUM_AXES];
    logic [NUM_AXES-1:0]    done_new;
    logic [PROD_W-1:0]      prod_add       [NUM_AXES];
    logic [TIME_BITS:0]     div_shift      [NUM_AXES];
    logic [NUM_AXES-1:0]    div_ge;
    logic [TIME_BITS-1:0]   rem_next       [NUM_AXES];
    logic [SPEED_BITS-1:0]  q_final        [NUM_AXES];
    logic [SPEED_BITS-1:0]  speed_new      [NUM_AXES];
    logic [STEP_W-1:0]      step_add       [NUM_AXES];
    logic [ANGLE_W-1:0]     acc_next       [NUM_AXES];
    logic                   accept;
    logic                   out_load;

    assign accept   = (state_reg == S_IDLE) && item.valid;
    assign out_load = (state_reg == S_OUT) && (!res_valid_reg || result.ready);

    always_comb
    begin
        if (phase_reg == PH_UNSTARTED)
        begin
            ph_eff = start_on_reg ? PH_NORMAL : PH_OFF;
        end
        else
        begin
            ph_eff = phase_reg;
        end
        ramp_up = (ph_eff == PH_UP);

        // phase after an accepted request, before any ramp completes
        case (item.mode)
            MODE_ON:  ph_acc = (ph_eff == PH_OFF) ? PH_UP : ph_eff;
            MODE_OFF: ph_acc = (ph_eff == PH_NORMAL) ? PH_DOWN : ph_eff;
            default:  ph_acc = ph_eff;
        endcase

        for (int a = 0; a < NUM_AXES; a++)
        begin
            t_up[a]  = TIME_BITS'(up_times_reg[a*RAMP_FIELD_W +: RAMP_FIELD_W]);
            t_dn[a]  = TIME_BITS'(down_times_reg[a*RAMP_FIELD_W +: RAMP_FIELD_W]);
            t_sel[a] = ramp_up ? t_up[a] : t_dn[a];

            // time left is loaded from a ramp time field or saturated, so the low bits
            // hold it whenever the sign is clear
            left_diff[a] = time_left_reg[a] - {2'b00, item.delta_time};
            left_new[a]  = left_diff[a][LEFT_W-1] ? '1 : left_diff[a];
            el_new[a]    = (left_diff[a][TIME_BITS-1:0] > t_sel[a]) ? '0 :
                           t_sel[a] - left_diff[a][TIME_BITS-1:0];
            done_new[a]  = (speed_reg[a] == '0) || left_diff[a][LEFT_W-1] ||
                           (t_sel[a] == '0);

            prod_add[a] = {prod_reg[a][PROD_W-2:0], 1'b0} +
                          (el_sh_reg[a][TIME_BITS-1] ? PROD_W'(speed_reg[a]) : '0);

            div_shift[a] = {rem_reg[a], prod_reg[a][PROD_W-1]};
            div_ge[a]    = div_shift[a] >= {1'b0, t_reg[a]};
            rem_next[a]  = div_ge[a] ? TIME_BITS'(div_shift[a] - {1'b0, t_reg[a]}) :
                           div_shift[a][TIME_BITS-1:0];
            q_final[a]   = SPEED_BITS'({prod_reg[a][PROD_W-2:0], div_ge[a]});

            if (done_reg[a])
            begin
                speed_new[a] = up_reg ? speed_reg[a] : '0;
            end
            else
            begin
                speed_new[a] = up_reg ? q_final[a] : speed_reg[a] - q_final[a];
            end

            // speed * dt, only the bits that survive the 16.16 wrap
            step_add[a] = {step_reg[a][STEP_W-2:0], 1'b0} +
                          (dt_sh_reg[TIME_BITS-1] ? STEP_W'(cur_speed_reg[a]) : '0);

            acc_next[a] = dir_reg[a] ?
                          acc_reg[a] + {step_reg[a], {(ANGLE_W-STEP_W){1'b0}}} :
                          acc_reg[a] - {step_reg[a], {(ANGLE_W-STEP_W){1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            phase_reg      <= PH_UNSTARTED;
            up_reg         <= 1'b0;
            dt_sh_reg      <= '0;
            dir_reg        <= '1;
            up_times_reg   <= '0;
            down_times_reg <= '0;
            start_on_reg   <= 1'b1;
            done_reg       <= '0;
            res_valid_reg  <= 1'b0;
            out_phase_reg  <= '0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                speed_reg[a]     <= '0;
                acc_reg[a]       <= '0;
                cur_speed_reg[a] <= '0;
                time_left_reg[a] <= '0;
                el_sh_reg[a]     <= '0;
                t_reg[a]         <= '0;
                prod_reg[a]      <= '0;
                rem_reg[a]       <= '0;
                step_reg[a]      <= '0;
                out_angle_reg[a] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SPEED_X:    speed_reg[0]   <= SPEED_BITS'(cfg_data);
                    CFG_SPEED_Y:    speed_reg[1]   <= SPEED_BITS'(cfg_data);
                    CFG_SPEED_Z:    speed_reg[2]   <= SPEED_BITS'(cfg_data);
                    CFG_DIRECTION:  dir_reg        <= cfg_data[DIR_W-1:0];
                    CFG_UP_TIMES:   up_times_reg   <= cfg_data[RAMP_PACK_W-1:0];
                    CFG_DOWN_TIMES: down_times_reg <= cfg_data[RAMP_PACK_W-1:0];
                    CFG_START_ON:   start_on_reg   <= cfg_data[0];
                    default:        ;
                endcase
            end

            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        dt_sh_reg <= item.delta_time;
                        phase_reg <= ph_acc;
                        if (phase_reg == PH_UNSTARTED)
                        begin
                            for (int a = 0; a < NUM_AXES; a++)
                            begin
                                cur_speed_reg[a] <= start_on_reg ? speed_reg[a] : '0;
                            end
                        end
                        case (item.mode)
                            MODE_TICK:
                            begin
                                if (ph_eff == PH_UP || ph_eff == PH_DOWN)
                                begin
                                    for (int a = 0; a < NUM_AXES; a++)
                                    begin
                                        time_left_reg[a] <= left_new[a];
                                        el_sh_reg[a]     <= el_new[a];
                                        t_reg[a]         <= t_sel[a];
                                        prod_reg[a]      <= '0;
                                    end
                                    done_reg  <= done_new;
                                    up_reg    <= ramp_up;
                                    cnt_reg   <= CNT_W'(TIME_BITS - 1);
                                    state_reg <= S_MUL_EL;
                                end
                                else if (ph_eff == PH_NORMAL)
                                begin
                                    for (int a = 0; a < NUM_AXES; a++)
                                    begin
                                        step_reg[a] <= '0;
                                    end
                                    cnt_reg   <= CNT_W'(TIME_BITS - 1);
                                    state_reg <= S_MUL_DT;
                                end
                                else
                                begin
                                    state_reg <= S_OUT;
                                end
                            end
                            MODE_ON:
                            begin
                                if (ph_eff == PH_OFF)
                                begin
                                    for (int a = 0; a < NUM_AXES; a++)
                                    begin
                                        time_left_reg[a] <= LEFT_W'(t_up[a]);
                                    end
                                end
                                state_reg <= S_OUT;
                            end
                            MODE_OFF:
                            begin
                                if (ph_eff == PH_NORMAL)
                                begin
                                    for (int a = 0; a < NUM_AXES; a++)
                                    begin
                                        time_left_reg[a] <= LEFT_W'(t_dn[a]);
                                    end
                                end
                                state_reg <= S_OUT;
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_MUL_EL:
                begin
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        prod_reg[a]  <= prod_add[a];
                        el_sh_reg[a] <= {el_sh_reg[a][TIME_BITS-2:0], 1'b0};
                    end
                    if (cnt_reg == '0)
                    begin
                        for (int a = 0; a < NUM_AXES; a++)
                        begin
                            rem_reg[a] <= '0;
                        end
                        cnt_reg   <= CNT_W'(PROD_W - 1);
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_DIV:
                begin
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        rem_reg[a]  <= rem_next[a];
                        prod_reg[a] <= {prod_reg[a][PROD_W-2:0], div_ge[a]};
                    end
                    if (cnt_reg == '0)
                    begin
                        for (int a = 0; a < NUM_AXES; a++)
                        begin
                            cur_speed_reg[a] <= speed_new[a];
                            step_reg[a]      <= '0;
                        end
                        cnt_reg   <= CNT_W'(TIME_BITS - 1);
                        state_reg <= S_MUL_DT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_MUL_DT:
                begin
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        step_reg[a] <= step_add[a];
                    end
                    dt_sh_reg <= {dt_sh_reg[TIME_BITS-2:0], 1'b0};
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_APPLY;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_APPLY:
                begin
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        acc_reg[a] <= acc_next[a];
                    end
                    if (&done_reg)
                    begin
                        if (phase_reg == PH_UP)
                        begin
                            phase_reg <= PH_NORMAL;
                        end
                        else if (phase_reg == PH_DOWN)
                        begin
                            phase_reg <= PH_OFF;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        for (int a = 0; a < NUM_AXES; a++)
                        begin
                            out_angle_reg[a] <= acc_reg[a][ANGLE_W-1 -: ANGLE_OUT_W];
                        end
                        out_phase_reg <= phase_reg[PHASE_OUT_W-1:0];
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item.ready         = (state_reg == S_IDLE);
    assign result.valid       = res_valid_reg;
    assign result.pitch_angle = out_angle_reg[0];
    assign result.yaw_angle   = out_angle_reg[1];
    assign result.roll_angle  = out_angle_reg[2];
    assign result.phase       = out_phase_reg;

    `TASRC_ASSERT_IMP(a_res_started, result.valid, phase_reg != PH_UNSTARTED)
    `TASRC_ASSERT_IMP(a_ramp_phase, state_reg == S_MUL_EL || state_reg == S_DIV,
                      phase_reg == PH_UP || phase_reg == PH_DOWN)
    `TASRC_ASSERT_IMP(a_rem_x, state_reg == S_DIV && t_reg[0] != '0, rem_reg[0] < t_reg[0])
    `TASRC_ASSERT_IMP(a_rem_z, state_reg == S_DIV && t_reg[2] != '0, rem_reg[2] < t_reg[2])
    `TASRC_ASSERT_NEXT(a_busy_after_accept, item.valid && item.ready, !item.ready)

endmodule
